FILE: rtl/irta_pkg.sv
// types, constants and microcode table for the radix-to-ascii converter
package irta_pkg;

  localparam int VALUE_W  = 31;
  localparam int RADIX_W  = 6;
  localparam int CHAR_W   = 7;
  localparam int DIGIT_W  = 6;
  localparam int BITCNT_W = 5;

  // one quotient bit per division step, so the last step is VALUE_W - 1
  localparam logic [BITCNT_W-1:0] DIV_LAST = BITCNT_W'(VALUE_W - 1);

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

  localparam logic [DIGIT_W-1:0] DEC_LIMIT   = 6'd10;
  localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 7'h30;
  // 'A' minus ten, added to digits ten and up
  localparam logic [CHAR_W-1:0]  ASCII_ALPHA = 7'h37;

  // microprogram addresses
  typedef enum logic [2:0] {
    STEP_IDLE,
    STEP_CHECK,
    STEP_DIV,
    STEP_STORE,
    STEP_EMIT_INIT,
    STEP_EMIT
  } step_t;

  // jump conditions
  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_START,
    COND_QUO_DONE,
    COND_BIT_LAST,
    COND_NO_DIGITS,
    COND_IDX_ZERO
  } cond_t;

  typedef struct packed {
    logic  load;      // take the input word, clear digit count
    logic  clr_div;   // clear remainder and bit counter
    logic  div_step;  // one restoring shift-subtract step
    logic  wr_digit;  // write remainder into store, bump count
    logic  rd_first;  // point read at the top digit
    logic  emit;      // drive one digit out, step read down
    cond_t cond;
    step_t tgt_true;
    step_t tgt_false;
  } ctl_word_t;

  function automatic ctl_word_t ucode(input step_t s);
    ctl_word_t w;
    w = '{load: 1'b0, clr_div: 1'b0, div_step: 1'b0, wr_digit: 1'b0,
          rd_first: 1'b0, emit: 1'b0, cond: COND_ALWAYS,
          tgt_true: STEP_IDLE, tgt_false: STEP_IDLE};
    case (s)
      STEP_IDLE: begin
        w.load      = 1'b1;
        w.cond      = COND_START;
        w.tgt_true  = STEP_CHECK;
        w.tgt_false = STEP_IDLE;
      end
      STEP_CHECK: begin
        w.clr_div   = 1'b1;
        w.cond      = COND_QUO_DONE;
        w.tgt_true  = STEP_EMIT_INIT;
        w.tgt_false = STEP_DIV;
      end
      STEP_DIV: begin
        w.div_step  = 1'b1;
        w.cond      = COND_BIT_LAST;
        w.tgt_true  = STEP_STORE;
        w.tgt_false = STEP_DIV;
      end
      STEP_STORE: begin
        w.wr_digit  = 1'b1;
        w.cond      = COND_ALWAYS;
        w.tgt_true  = STEP_CHECK;
        w.tgt_false = STEP_CHECK;
      end
      STEP_EMIT_INIT: begin
        w.rd_first  = 1'b1;
        w.cond      = COND_NO_DIGITS;
        w.tgt_true  = STEP_IDLE;
        w.tgt_false = STEP_EMIT;
      end
      STEP_EMIT: begin
        w.emit      = 1'b1;
        w.cond      = COND_IDX_ZERO;
        w.tgt_true  = STEP_IDLE;
        w.tgt_false = STEP_EMIT;
      end
      default: begin
        w.cond      = COND_ALWAYS;
        w.tgt_true  = STEP_IDLE;
        w.tgt_false = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/integer_radix_to_ascii_digits.sv
// top level: microcoded integer to radix-digit ascii converter
//
// one word enters when start is high and busy is low; busy then stays high
// until the last digit has been scheduled. the value is divided by the radix
// over and over with a one-bit-per-cycle restoring divider, each remainder
// kept in a small digit store, and the digits then leave most significant
// first, one per cycle, each marked by a single-cycle out_valid strobe. the
// receiver cannot stall, so it must take every strobed word. the final digit
// carries out_last_digit; a zero value gives no words at all. each digit
// costs a check step, 31 divider steps and a store step; the digits are
// then emitted one per cycle through an output register. the divider loop
// takes most of the time. the radix register is read when a word is
// accepted; values below 2 act as 2, above 36 as 36.
module integer_radix_to_ascii_digits #(
  parameter int MAX_DIGITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [irta_pkg::VALUE_W-1:0]  in_value,
  input  logic                          cfg_we,
  input  logic [irta_pkg::RADIX_W-1:0]  cfg_wdata,
  output logic                          out_valid,
  output logic [irta_pkg::CHAR_W-1:0]   out_digit_char,
  output logic                          out_last_digit
);
  import irta_pkg::*;

  // at most min(MAX_DIGITS, 31) digits are kept
  localparam int CAP   = (MAX_DIGITS < VALUE_W) ? MAX_DIGITS : VALUE_W;
  localparam int CNT_W = $clog2(CAP + 1);
  localparam int AW    = $clog2(MAX_DIGITS);

  // sequencer
  step_t     upc_r, upc_nxt;
  ctl_word_t cw;
  logic      cond_hit;

  // datapath registers
  logic [RADIX_W-1:0]  radix_r, radix_nxt;
  logic [RADIX_W-1:0]  base_r, base_nxt;
  logic [VALUE_W-1:0]  quo_r, quo_nxt;
  logic [DIGIT_W-1:0]  rem_r, rem_nxt;
  logic [BITCNT_W-1:0] bitcnt_r, bitcnt_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [AW-1:0]       idx_r, idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]   out_char_r, out_char_nxt;
  logic                out_last_r, out_last_nxt;

  // digit store
  logic [DIGIT_W-1:0]  store_mem [MAX_DIGITS];
  logic [DIGIT_W-1:0]  rd_data_r;
  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       wr_addr;
  logic                accept;

  // divider step signals
  logic [DIGIT_W:0]    part_rem;
  logic                sub_ok;
  logic [DIGIT_W:0]    part_diff;
  logic [CNT_W-1:0]    cnt_dec;

  assign cw      = ucode(upc_r);
  assign accept  = start && (upc_r == STEP_IDLE);
  assign busy    = (upc_r != STEP_IDLE);
  assign wr_addr = AW'(cnt_r);
  assign cnt_dec = cnt_r - CNT_W'(1);

  // restoring division: bring in the next quotient bit, subtract if it fits
  assign part_rem  = {rem_r, quo_r[VALUE_W-1]};
  assign sub_ok    = (part_rem >= {1'b0, base_r});
  assign part_diff = part_rem - {1'b0, base_r};

  // jump condition select
  always_comb begin
    case (cw.cond)
      COND_ALWAYS:    cond_hit = 1'b1;
      COND_START:     cond_hit = start;
      COND_QUO_DONE:  cond_hit = (quo_r == '0) || (cnt_r == CNT_W'(CAP));
      COND_BIT_LAST:  cond_hit = (bitcnt_r == DIV_LAST);
      COND_NO_DIGITS: cond_hit = (cnt_r == '0);
      COND_IDX_ZERO:  cond_hit = (idx_r == '0);
      default:        cond_hit = 1'b0;
    endcase
  end

  // read address: top digit first, then walk down one entry per cycle
  always_comb begin
    if (cw.rd_first) begin
      rd_addr = AW'(cnt_dec);
    end else begin
      rd_addr = idx_r - AW'(1);
    end
  end

  always_comb begin
    upc_nxt       = cond_hit ? cw.tgt_true : cw.tgt_false;
    radix_nxt     = radix_r;
    base_nxt      = base_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    bitcnt_nxt    = bitcnt_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    out_valid_nxt = 1'b0;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    if (cfg_we) begin
      radix_nxt = cfg_wdata;
    end

    // latch the input word and the clamped radix
    if (cw.load && accept) begin
      quo_nxt = in_value;
      cnt_nxt = '0;
      if (radix_r < RADIX_MIN) begin
        base_nxt = RADIX_MIN;
      end else if (radix_r > RADIX_MAX) begin
        base_nxt = RADIX_MAX;
      end else begin
        base_nxt = radix_r;
      end
    end

    if (cw.clr_div) begin
      rem_nxt    = '0;
      bitcnt_nxt = '0;
    end

    if (cw.div_step) begin
      quo_nxt    = {quo_r[VALUE_W-2:0], sub_ok};
      rem_nxt    = sub_ok ? part_diff[DIGIT_W-1:0] : part_rem[DIGIT_W-1:0];
      bitcnt_nxt = bitcnt_r + BITCNT_W'(1);
    end

    if (cw.wr_digit) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end

    if (cw.rd_first) begin
      idx_nxt = AW'(cnt_dec);
    end

    // rd_data_r holds store[idx_r] here
    if (cw.emit) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = (idx_r == '0);
      if (rd_data_r < DEC_LIMIT) begin
        out_char_nxt = ASCII_ZERO + CHAR_W'(rd_data_r);
      end else begin
        out_char_nxt = ASCII_ALPHA + CHAR_W'(rd_data_r);
      end
      idx_nxt = idx_r - AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= STEP_IDLE;
      radix_r     <= RADIX_RESET;
      base_r      <= RADIX_RESET;
      quo_r       <= '0;
      rem_r       <= '0;
      bitcnt_r    <= '0;
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      upc_r       <= upc_nxt;
      radix_r     <= radix_nxt;
      base_r      <= base_nxt;
      quo_r       <= quo_nxt;
      rem_r       <= rem_nxt;
      bitcnt_r    <= bitcnt_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output payload needs no reset
  always_ff @(posedge clk) begin
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  // digit store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cw.wr_digit) begin
      store_mem[wr_addr] <= rem_r;
    end
    rd_data_r <= store_mem[rd_addr];
  end

  assign out_valid      = out_valid_r;
  assign out_digit_char = out_char_r;
  assign out_last_digit = out_last_r;

endmodule

FILE: rtl/irta_checker.sv
// port-level checker for the radix-to-ascii converter, bound to the top level
module irta_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic [irta_pkg::CHAR_W-1:0]   out_digit_char,
  input logic                          out_last_digit
);
  import irta_pkg::*;

  // an accepted word keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // the first digit never comes right after an accept
  a_no_out_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_valid)
    else $error("digit strobed right after accept");

  // digits of one run leave back to back until the last one
  a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_digit) |=> out_valid)
    else $error("gap inside a digit run");

  // every digit is '0'-'9' or 'A'-'Z'
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_digit_char >= 7'h30 && out_digit_char <= 7'h39) ||
                   (out_digit_char >= 7'h41 && out_digit_char <= 7'h5A)))
    else $error("digit character out of range");

endmodule

bind integer_radix_to_ascii_digits irta_checker u_irta_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_digit_char (out_digit_char),
  .out_last_digit (out_last_digit)
);
